>>> sv/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared definitions for the multi-stack shared pool
// Pool geometry, operation and status codes, beat payload types, the
// controller/datapath command and status structs, and the value output helper.
// ----------------------------------------------------------------------------
package msp_pkg;

    // Pool geometry.
    localparam int POOL_DEPTH  = 128;
    localparam int DATA_WIDTH  = 32;
    localparam int NUM_STACKS  = 3;

    localparam int ADDR_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
    localparam int SIDX_W      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int ENTRY_W     = DATA_WIDTH + ADDR_W;

    // The free-slot search looks at the used bits in groups of eight.
    localparam int GROUP_SIZE  = 8;
    localparam int GROUP_IDX_W = 3;
    localparam int NUM_GROUPS  = (POOL_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    // Operation codes.
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         stack_sel;
        logic signed [31:0] push_value;
    } in_item_t;

    // Result beat.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] top_value;
        logic [7:0]         stack_count;
        logic               is_empty;
    } out_item_t;

    // Lowest free slot, or full when every slot is taken.
    typedef struct packed {
        logic              full;
        logic [ADDR_W-1:0] slot;
    } free_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic reread;
        logic fill;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    // Sign-extend a stored value and return its low 32 bits.
    function automatic logic [31:0] value_out(input logic [DATA_WIDTH-1:0] stored);
        logic signed [63:0] wide;
        wide = 64'(signed'(stored));
        return wide[31:0];
    endfunction

endpackage

>>> sv/msp_ram.sv
// ----------------------------------------------------------------------------
// msp_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/msp_free_finder.sv
// ----------------------------------------------------------------------------
// msp_free_finder: lowest free slot search
// A two-level registered search over the used bits: the first level finds
// the lowest free bit in each group of eight, the second the lowest group
// with a free bit. Both levels are registered; the answer lags the used bits.
// ----------------------------------------------------------------------------
module msp_free_finder
    import msp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [POOL_DEPTH-1:0] used_i,
    output free_t                 free_o
);

    logic [NUM_GROUPS*GROUP_SIZE-1:0] padded;
    logic [NUM_GROUPS-1:0]            grp_free_reg;
    logic [NUM_GROUPS-1:0]            grp_free_next;
    logic [GROUP_IDX_W-1:0]           grp_idx_reg  [NUM_GROUPS];
    logic [GROUP_IDX_W-1:0]           grp_idx_next [NUM_GROUPS];
    free_t                            free_reg;
    free_t                            free_next;

    // First level: lowest free bit within each group. Padding reads as used.
    always_comb begin
        padded = '1;
        padded[POOL_DEPTH-1:0] = used_i;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_free_next[g] = ~&padded[g*GROUP_SIZE +: GROUP_SIZE];
            grp_idx_next[g]  = '0;
            for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
                if (!padded[g*GROUP_SIZE + j]) begin
                    grp_idx_next[g] = GROUP_IDX_W'(j);
                end
            end
        end
    end

    // Second level: lowest group that has a free bit.
    always_comb begin
        free_next.full = 1'b1;
        free_next.slot = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (grp_free_reg[g]) begin
                free_next.full = 1'b0;
                free_next.slot = ADDR_W'(g * GROUP_SIZE + int'(grp_idx_reg[g]));
            end
        end
    end

    // Both levels reset to the all-free answer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_free_reg <= '1;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                grp_idx_reg[g] <= '0;
            end
            free_reg <= '{full: 1'b0, slot: '0};
        end else begin
            grp_free_reg <= grp_free_next;
            grp_idx_reg  <= grp_idx_next;
            free_reg     <= free_next;
        end
    end

    assign free_o = free_reg;

endmodule

>>> sv/msp_datapath.sv
// ----------------------------------------------------------------------------
// msp_datapath: pool storage, stack registers and result register
// Holds the entry RAM (value and link below), the used bits, each stack's
// top index and count, and the result register that drives the m_ side.
// ----------------------------------------------------------------------------
module msp_datapath
    import msp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       cmd_i,
    output dp_status_t status_o,
    input  in_item_t   s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_payload
);

    in_item_t          item_reg;
    logic [POOL_DEPTH-1:0] used_reg;
    logic [POOL_DEPTH-1:0] used_next;
    logic [ADDR_W-1:0] top_reg  [NUM_STACKS];
    logic [ADDR_W-1:0] top_next [NUM_STACKS];
    logic [CNT_W-1:0]  cnt_reg  [NUM_STACKS];
    logic [CNT_W-1:0]  cnt_next [NUM_STACKS];
    logic [1:0]        res_status_reg;
    logic [1:0]        res_status_next;
    out_item_t         m_payload_reg;
    out_item_t         m_payload_next;
    logic              m_valid_reg;
    logic              m_valid_next;

    logic [1:0]        cur_sel;
    logic              cur_in_range;
    logic [SIDX_W-1:0] cur_idx;
    logic              item_in_range;
    logic [SIDX_W-1:0] item_idx;
    logic              push_ok;
    logic              pop_ok;
    logic [DATA_WIDTH-1:0] push_data;
    logic              rd_en;
    logic [ENTRY_W-1:0] rd_data;
    logic [ADDR_W-1:0] rd_below;
    logic [DATA_WIDTH-1:0] rd_value;
    free_t             free;

    // Stack selection: the incoming beat while loading, the held item after.
    assign cur_sel       = cmd_i.load_item ? s_payload.stack_sel : item_reg.stack_sel;
    assign cur_in_range  = int'(cur_sel) < NUM_STACKS;
    assign cur_idx       = cur_in_range ? SIDX_W'(cur_sel) : '0;
    assign item_in_range = int'(item_reg.stack_sel) < NUM_STACKS;
    assign item_idx      = item_in_range ? SIDX_W'(item_reg.stack_sel) : '0;

    // Operation outcome for the held item.
    assign push_ok   = item_in_range && (item_reg.opcode == OP_PUSH) && !free.full;
    assign pop_ok    = item_in_range && (item_reg.opcode == OP_POP)
                       && (cnt_reg[item_idx] != '0);
    assign push_data = DATA_WIDTH'($unsigned(item_reg.push_value));

    // Entry storage: value above, link to the entry below in the low bits.
    assign rd_en    = cmd_i.load_item | cmd_i.reread;
    assign rd_below = rd_data[ADDR_W-1:0];
    assign rd_value = rd_data[ENTRY_W-1:ADDR_W];

    msp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (cmd_i.exec && push_ok),
        .wr_addr (free.slot),
        .wr_data ({push_data, top_reg[item_idx]}),
        .rd_en   (rd_en),
        .rd_addr (top_reg[cur_idx]),
        .rd_data (rd_data)
    );

    msp_free_finder u_free_finder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .used_i  (used_reg),
        .free_o  (free)
    );

    // Status of the operation.
    always_comb begin
        res_status_next = res_status_reg;
        if (cmd_i.exec) begin
            if (!item_in_range) begin
                res_status_next = ST_EMPTY;
            end else begin
                case (item_reg.opcode) inside
                    OP_PUSH: res_status_next = free.full ? ST_FULL : ST_OK;
                    OP_POP: begin
                        res_status_next = (cnt_reg[item_idx] == '0) ? ST_EMPTY : ST_OK;
                    end
                    OP_PEEK, OP_RSVD: begin
                        res_status_next = (cnt_reg[item_idx] == '0) ? ST_EMPTY : ST_OK;
                    end
                endcase
            end
        end
    end

    // Stack and used-bit updates.
    always_comb begin
        used_next = used_reg;
        top_next  = top_reg;
        cnt_next  = cnt_reg;
        if (cmd_i.exec && push_ok) begin
            used_next[free.slot] = 1'b1;
            top_next[item_idx]   = free.slot;
            cnt_next[item_idx]   = cnt_reg[item_idx] + CNT_W'(1);
        end
        if (cmd_i.exec && pop_ok) begin
            used_next[top_reg[item_idx]] = 1'b0;
            cnt_next[item_idx]           = cnt_reg[item_idx] - CNT_W'(1);
            top_next[item_idx] = (cnt_reg[item_idx] == CNT_W'(1)) ? '0 : rd_below;
        end
    end

    // Result register: loads on fill, drains on m_ready.
    always_comb begin
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg;
        if (cmd_i.fill) begin
            m_valid_next          = 1'b1;
            m_payload_next.status = res_status_reg;
            if (item_in_range && (cnt_reg[item_idx] != '0)) begin
                m_payload_next.top_value   = value_out(rd_value);
                m_payload_next.stack_count = 8'(cnt_reg[item_idx]);
                m_payload_next.is_empty    = 1'b0;
            end else begin
                m_payload_next.top_value   = '0;
                m_payload_next.stack_count = '0;
                m_payload_next.is_empty    = 1'b1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                top_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else begin
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            top_reg     <= top_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd_i.load_item) begin
            item_reg <= s_payload;
        end
        res_status_reg <= res_status_next;
        m_payload_reg  <= m_payload_next;
    end

    assign status_o.out_busy = m_valid_reg && !m_ready;
    assign m_valid           = m_valid_reg;
    assign m_payload         = m_payload_reg;

`ifndef SYNTHESIS
    // The controller must not overwrite a result that is still waiting.
    a_fill_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.fill |-> !status_o.out_busy)
        else $error("result register loaded while its beat was pending");

    // A successful push marks its slot as used.
    a_push_marks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.exec && push_ok) |=> used_reg[$past(free.slot)])
        else $error("pushed slot not marked used");

    // A stack outside the range never touches the pool.
    a_out_of_range_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.exec && !item_in_range) |=> $stable(used_reg))
        else $error("out-of-range stack changed the used bits");

    // A result beat only appears after a fill command.
    a_valid_from_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd_i.fill))
        else $error("result beat raised without a fill");
`endif

endmodule

>>> sv/msp_ctrl.sv
// ----------------------------------------------------------------------------
// msp_ctrl: operation sequencer
// Steps each accepted beat through execute, top re-read and result fill,
// holding in fill while the previous result beat has not been taken.
// ----------------------------------------------------------------------------
module msp_ctrl
    import msp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output cmd_t       cmd_o,
    input  dp_status_t status_i
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_REREAD = 2'd2;
    localparam logic [1:0] S_FILL   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_EXEC;
            S_EXEC:   state_next = S_REREAD;
            S_REREAD: state_next = S_FILL;
            S_FILL:   if (!status_i.out_busy) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath.
    assign s_ready         = (state_reg == S_IDLE);
    assign cmd_o.load_item = s_valid && s_ready;
    assign cmd_o.exec      = (state_reg == S_EXEC);
    assign cmd_o.reread    = (state_reg == S_REREAD);
    assign cmd_o.fill      = (state_reg == S_FILL) && !status_i.out_busy;

`ifndef SYNTHESIS
    // A pending result holds the sequencer in fill.
    a_hold_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL && status_i.out_busy) |=> (state_reg == S_FILL))
        else $error("left fill while the result beat was pending");
`endif

endmodule

>>> sv/multi_stack_shared_pool.sv
// A result beat is registered in fill, after the execute and top re-read states.
// One beat at a time runs accept with link read, execute, top re-read and fill;
// the link must be read before execute and the new top re-read after it.
// A result beat still waiting holds the next item in fill, so input stalls after one.
// Reset (aresetn, synchronous, active low) frees every slot and empties all
// stacks at once; entry RAM contents are left as they are, with no clear pass.
// ----------------------------------------------------------------------------
// multi_stack_shared_pool: several stacks linked through one entry pool
// Push takes the lowest free slot and links it to the stack's old top; pop
// frees the top and restores the entry below. Each beat returns one result.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool
    import msp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    cmd_t       cmd;
    dp_status_t dp_status;

    msp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .cmd_o    (cmd),
        .status_i (dp_status)
    );

    msp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_i     (cmd),
        .status_o  (dp_status),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

>>> dv/tb_multi_stack_shared_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_stack_shared_pool: self-checking bench for the shared-pool stacks
// Walks a directed table from reset, then random phases that fill the pool,
// churn it into holes, drain it, and build one stack to full depth. Every
// result beat is checked against a typed row's expectation or an in-bench pool
// model, with random stalls on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_multi_stack_shared_pool;
    import msp_pkg::*;

    localparam int N_DIRECTED    = 25;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 400;
    localparam int SETTLE_CYCLES = 16;

    // Result of any operation that is rejected with the empty status.
    localparam out_item_t EMPTY_REJECT = '{ST_EMPTY, 32'sd0, 8'd0, 1'b1};
    localparam out_item_t EMPTY_AFTER_POP = '{ST_OK, 32'sd0, 8'd0, 1'b1};

    typedef struct packed {
        in_item_t  beat;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    // Directed rows from reset; typed rows carry their expected result.
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{'{OP_PEEK, 2'd0, 32'sd0}, 1'b1, EMPTY_REJECT},
        '{'{OP_POP,  2'd1, 32'sd0}, 1'b1, EMPTY_REJECT},
        '{'{OP_RSVD, 2'd2, 32'sd0}, 1'b1, EMPTY_REJECT},
        '{'{OP_PUSH, 2'd3, 32'sh7fffffff}, 1'b1, EMPTY_REJECT},
        '{'{OP_POP,  2'd3, 32'sd0}, 1'b1, EMPTY_REJECT},
        '{'{OP_PUSH, 2'd0, 32'sh7fffffff}, 1'b1, '{ST_OK, 32'sh7fffffff, 8'd1, 1'b0}},
        '{'{OP_PUSH, 2'd1, 32'sh80000000}, 1'b1, '{ST_OK, 32'sh80000000, 8'd1, 1'b0}},
        '{'{OP_PUSH, 2'd2, -32'sd1}, 1'b1, '{ST_OK, -32'sd1, 8'd1, 1'b0}},
        '{'{OP_PUSH, 2'd0, -32'sd2}, 1'b1, '{ST_OK, -32'sd2, 8'd2, 1'b0}},
        '{'{OP_PEEK, 2'd0, 32'sd0}, 1'b1, '{ST_OK, -32'sd2, 8'd2, 1'b0}},
        '{'{OP_RSVD, 2'd1, 32'sd5}, 1'b1, '{ST_OK, 32'sh80000000, 8'd1, 1'b0}},
        '{'{OP_PEEK, 2'd3, 32'sd0}, 1'b1, EMPTY_REJECT},
        '{'{OP_POP,  2'd1, 32'sd0}, 1'b1, EMPTY_AFTER_POP},
        '{'{OP_PUSH, 2'd2, 32'sd0}, 1'b0, '0},
        '{'{OP_POP,  2'd0, 32'sd0}, 1'b0, '0},
        '{'{OP_PUSH, 2'd0, 32'sh12345678}, 1'b0, '0},
        '{'{OP_PUSH, 2'd1, 32'sh55555555}, 1'b0, '0},
        '{'{OP_PUSH, 2'd1, 32'shaaaaaaaa}, 1'b0, '0},
        '{'{OP_POP,  2'd2, 32'sd0}, 1'b0, '0},
        '{'{OP_POP,  2'd2, 32'sd0}, 1'b0, '0},
        '{'{OP_POP,  2'd2, 32'sd0}, 1'b0, '0},
        '{'{OP_PEEK, 2'd0, 32'sd0}, 1'b0, '0},
        '{'{OP_RSVD, 2'd3, -32'sd1}, 1'b1, EMPTY_REJECT},
        '{'{OP_POP,  2'd0, 32'sd0}, 1'b0, '0},
        '{'{OP_POP,  2'd0, 32'sd0}, 1'b0, '0}
    };

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_payload;

    // Expectation carried alongside the beat on offer.
    logic      cur_typed = 1'b0;
    out_item_t cur_want  = '0;

    // Model of the pool.
    logic [DATA_WIDTH-1:0] slot_val  [POOL_DEPTH];
    logic [ADDR_W-1:0]     slot_link [POOL_DEPTH];
    bit                    slot_busy [POOL_DEPTH];
    int                    top_slot  [NUM_STACKS];
    int                    depth_of  [NUM_STACKS];
    int                    free_ptr;

    out_item_t pending_results [$];

    int  failures      = 0;
    int  results_seen  = 0;
    int  beats_offered = 0;
    int  stall_cycles  = 0;
    int  idle_pct      = 0;
    bit  quiet_tail    = 1'b0;
    int  n_push = 0, n_pop = 0, n_peek = 0, n_full = 0, n_empty = 0, peak_depth = 0;

    multi_stack_shared_pool i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one beat to the pool model and describe the selected stack after it.
    function automatic out_item_t pool_apply(input in_item_t it);
        logic [1:0]  st;
        logic [63:0] wide;
        int          sel;
        int          slot;
        out_item_t   r;
        sel = int'(it.stack_sel);
        st  = ST_OK;
        if (sel >= NUM_STACKS) begin
            st = ST_EMPTY;
        end else if (it.opcode == OP_PUSH) begin
            if (free_ptr >= POOL_DEPTH) begin
                st = ST_FULL;
            end else begin
                slot = free_ptr;
                wide = '0;
                wide[31:0] = it.push_value;
                slot_val[slot]  = wide[DATA_WIDTH-1:0];
                slot_link[slot] = ADDR_W'(top_slot[sel]);
                slot_busy[slot] = 1'b1;
                top_slot[sel]   = slot;
                depth_of[sel]++;
                while (free_ptr < POOL_DEPTH && slot_busy[free_ptr])
                    free_ptr++;
            end
        end else if (it.opcode == OP_POP) begin
            if (depth_of[sel] == 0) begin
                st = ST_EMPTY;
            end else begin
                slot = top_slot[sel];
                if (slot < free_ptr)
                    free_ptr = slot;
                slot_busy[slot] = 1'b0;
                top_slot[sel]   = int'(slot_link[slot]);
                depth_of[sel]--;
                if (depth_of[sel] == 0)
                    top_slot[sel] = 0;
            end
        end else if (depth_of[sel] == 0) begin
            // Peek, and the unused opcode acting as one.
            st = ST_EMPTY;
        end

        r.status = st;
        if (sel < NUM_STACKS && depth_of[sel] != 0) begin
            wide = {64{slot_val[top_slot[sel]][DATA_WIDTH-1]}};
            wide[DATA_WIDTH-1:0] = slot_val[top_slot[sel]];
            r.top_value   = wide[31:0];
            r.stack_count = 8'(depth_of[sel]);
            r.is_empty    = 1'b0;
        end else begin
            r.top_value   = '0;
            r.stack_count = '0;
            r.is_empty    = 1'b1;
        end
        return r;
    endfunction

    // Random beat with the given push and pop shares in percent.
    function automatic in_item_t make_beat(input int push_pct, input int pop_pct);
        in_item_t b;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            b.opcode = OP_PUSH;
        else if (roll < push_pct + pop_pct)
            b.opcode = OP_POP;
        else
            b.opcode = ($urandom_range(0, 3) == 0) ? OP_RSVD : OP_PEEK;
        if ($urandom_range(0, 15) == 0)
            b.stack_sel = 2'($urandom_range(NUM_STACKS, 3));
        else
            b.stack_sel = 2'($urandom_range(0, NUM_STACKS - 1));
        case ($urandom_range(0, 11))
            0: b.push_value = 32'sh7fffffff;
            1: b.push_value = 32'sh80000000;
            2: b.push_value = '0;
            3: b.push_value = '1;
            default: b.push_value = $urandom;
        endcase
        return b;
    endfunction

    // Offer one beat at the falling edge and hold it until it is taken.
    task automatic send_beat(input in_item_t beat, input logic typed, input out_item_t want);
        if (beats_offered % 40 == 0) begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 50;
            endcase
        end
        if (!quiet_tail && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        cur_typed <= typed;
        cur_want  <= want;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        beats_offered++;
    endtask

    // Predict accepted beats, check result beats, and watch for a hang.
    always @(posedge aclk) begin : monitor
        out_item_t guess;
        out_item_t got;
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                guess = pool_apply(s_payload);
                pending_results.push_back(cur_typed ? cur_want : guess);
                if (s_payload.opcode == OP_PUSH)
                    n_push++;
                else if (s_payload.opcode == OP_POP)
                    n_pop++;
                else
                    n_peek++;
                if (guess.status == ST_FULL)
                    n_full++;
                if (guess.status == ST_EMPTY)
                    n_empty++;
                if (int'(guess.stack_count) > peak_depth)
                    peak_depth = int'(guess.stack_count);
            end
            if (m_valid && m_ready) begin
                got = m_payload;
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        failures++;
                    end
                    if (got.top_value !== want.top_value) begin
                        $error("top_value: expected %0d, actual %0d",
                               want.top_value, got.top_value);
                        failures++;
                    end
                    if (got.stack_count !== want.stack_count) begin
                        $error("stack_count: expected %0d, actual %0d",
                               want.stack_count, got.stack_count);
                        failures++;
                    end
                    if (got.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, actual %0d",
                               want.is_empty, got.is_empty);
                        failures++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Result side: random ready bursts, one long hold-off, then always ready.
    initial begin : receiver
        int  stall_pct;
        bit  held;
        stall_pct = 25;
        held      = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (quiet_tail) begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end else if (!held && results_seen >= HOLD_AFTER) begin
                // Long hold-off so the block backs up and stalls its input.
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if ($urandom_range(0, 19) == 0) begin
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        default: stall_pct = 60;
                    endcase
                end
                if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 9)) @(negedge aclk);
                end else begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 12)) @(negedge aclk);
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial begin : stimulus
        in_item_t beat;
        int       tower;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            slot_val[i]  = '0;
            slot_link[i] = '0;
            slot_busy[i] = 1'b0;
        end
        for (int i = 0; i < NUM_STACKS; i++) begin
            top_slot[i] = 0;
            depth_of[i] = 0;
        end
        free_ptr = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        // Mixed traffic over all stacks.
        for (int i = 0; i < 250; i++)
            send_beat(make_beat(40, 35), 1'b0, '0);

        // Push-heavy until the pool is full and pushes get rejected.
        for (int i = 0; i < 170; i++)
            send_beat(make_beat(85, 5), 1'b0, '0);

        // Churn near full so freed slots open holes below the free pointer.
        for (int i = 0; i < 200; i++)
            send_beat(make_beat(35, 45), 1'b0, '0);

        // Empty every stack so the pool is clear again.
        for (int s = 0; s < NUM_STACKS; s++) begin
            while (depth_of[s] != 0) begin
                beat = '{OP_POP, 2'(s), 32'sd0};
                send_beat(beat, 1'b0, '0);
            end
        end

        // One stack takes the whole pool, then a few pushes past full.
        tower = $urandom_range(0, NUM_STACKS - 1);
        for (int i = 0; i < POOL_DEPTH + 3; i++) begin
            beat = make_beat(100, 0);
            beat.stack_sel = 2'(tower);
            send_beat(beat, 1'b0, '0);
        end

        // Unwind it, ending with a pop of the empty stack.
        while (depth_of[tower] != 0) begin
            beat = '{OP_POP, 2'(tower), 32'sd0};
            send_beat(beat, 1'b0, '0);
        end
        beat = '{OP_POP, 2'(tower), 32'sd0};
        send_beat(beat, 1'b0, '0);

        // Last stretch at full rate on both sides.
        quiet_tail = 1'b1;
        for (int i = 0; i < 150; i++)
            send_beat(make_beat(40, 35), 1'b0, '0);
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d beats (%0d push, %0d pop, %0d peek), %0d results checked.",
                 beats_offered, n_push, n_pop, n_peek, results_seen);
        $display("Saw %0d pool-full and %0d empty-stack rejections; deepest stack %0d.",
                 n_full, n_empty, peak_depth);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
